// ===== rtl/core/pipr_pkg.sv =====
// Shared types and codes of the point-in-polygon ray cast block.
`default_nettype none

package pipr_pkg;

    // Item kinds carried in the input tuser bit.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CROSS_W = 6;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAX,
        ST_EDGE,
        ST_DRAIN
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear;        // start a query: capture point, reset maxima and count
        logic load_vertex;  // write the input vertex into the table
        logic rd_en;        // read one table entry
        logic rd_edge;      // the read belongs to the edge pass
        logic rd_first;     // the read is entry zero of the edge pass
        logic out_load;     // move the count into the output register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic busy;         // reads or edge tests still in flight
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/point_in_polygon_ray_cast.sv =====
// Top level of the point-in-polygon ray cast block.
//
//  channel   direction  signals                         carries
//  s         in         i_s_tvalid/o_s_tready, tdata/tuser  load vertex or query point
//  m         out        o_m_tvalid/i_m_tready, tdata      crossing result, one per query
//  cfg       in         i_cfg_valid/o_cfg_ready, data     vertex count register
//
// A load is taken whenever the block is idle. A query holds the input through the request cycle,
// the maxima sweep and the edge sweep of the table's single read port, and the drain of the read
// register and the four-stage edge test pipeline.
// Reset clears the controller, the pipeline valid bits and the output; the table is not cleared.
// A stalled result sits in the output register; loads are still taken, a query waits at its end.
`default_nettype none

module point_in_polygon_ray_cast
    import pipr_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    // index, x, y from bit 0 up, zero padded to whole bytes
    input  wire [((IDX_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    // operation
    input  wire [0:0]                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    // inside_res, crossing_count from bit 0 up, one pad bit
    output logic [7:0]                 o_m_tdata,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [COUNT_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    t_dp_cmd                  w_cmd;
    t_dp_sts                  w_sts;
    logic [AW-1:0]            w_rd_addr;
    logic [IDX_W-1:0]         w_index;
    logic signed [COORD_WIDTH-1:0] w_x, w_y;
    logic                     w_inside;
    logic [CROSS_W-1:0]       w_cross;

    assign w_index = i_s_tdata[IDX_W-1:0];
    assign w_x     = i_s_tdata[IDX_W +: COORD_WIDTH];
    assign w_y     = i_s_tdata[IDX_W + COORD_WIDTH +: COORD_WIDTH];

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {1'b0, w_cross, w_inside};

    pipr_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_operation (i_s_tuser[0]),
        .i_index     (w_index),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    pipr_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_rd_addr        (w_rd_addr),
        .i_index          (w_index),
        .i_x              (w_x),
        .i_y              (w_y),
        .i_m_tready       (i_m_tready),
        .o_sts            (w_sts),
        .o_out_valid      (o_m_tvalid),
        .o_inside_res     (w_inside),
        .o_crossing_count (w_cross)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pipr_datapath.sv =====
// Vertex table, maxima tracking, pipelined edge crossing test and output register.
`default_nettype none

module pipr_datapath
    import pipr_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    input  wire [$clog2(MAX_VERTICES)-1:0] i_rd_addr,
    input  wire [IDX_W-1:0]              i_index,
    input  wire signed [COORD_WIDTH-1:0] i_x,
    input  wire signed [COORD_WIDTH-1:0] i_y,
    input  wire                          i_m_tready,
    output t_dp_sts                      o_sts,
    output logic                         o_out_valid,
    output logic                         o_inside_res,
    output logic [CROSS_W-1:0]           o_crossing_count
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int W   = COORD_WIDTH;
    localparam int S1W = W + 2;        // target minus point
    localparam int S2W = W + 1;        // edge vector and point offset
    localparam int PW  = S1W + S2W;    // one product
    localparam int SW  = PW + 1;       // difference of two products

    logic signed [W-1:0] r_mem_x [MAX_VERTICES];
    logic signed [W-1:0] r_mem_y [MAX_VERTICES];

    logic signed [W-1:0] r_rd_x, r_rd_y;
    logic                r_rd_valid, r_rd_edge, r_rd_first;

    logic signed [W-1:0] r_px, r_py, r_max_x, r_max_y;
    logic signed [W-1:0] r_ax, r_ay;

    logic signed [S1W-1:0] r_s1x, r_s1y;
    logic signed [S2W-1:0] r_s2x, r_s2y, r_dx, r_dy;
    logic                  r_v1;

    logic signed [PW-1:0] r_p_den1, r_p_den2, r_p_sn1, r_p_sn2, r_p_tn1, r_p_tn2;
    logic                 r_v2;

    logic signed [SW-1:0] r_den, r_sn, r_tn;
    logic                 r_v3;

    logic [CROSS_W-1:0] r_count;
    logic               r_out_valid;
    logic [CROSS_W-1:0] r_out_count;

    logic signed [S1W-1:0] w_s1x, w_s1y;
    logic signed [S2W-1:0] w_s2x, w_s2y, w_dx, w_dy;
    logic                  w_sn_ok, w_tn_ok, w_crossed;

    // Table: one write port for loads, one registered read port for the sweeps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vertex) begin
            r_mem_x[AW'(i_index)] <= i_x;
            r_mem_y[AW'(i_index)] <= i_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_rd_addr];
            r_rd_y <= r_mem_y[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_edge  <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            r_rd_edge  <= i_cmd.rd_edge;
            r_rd_first <= i_cmd.rd_first;
        end
    end

    // Maxima start at the most negative coordinate for every query.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_px    <= i_x;
            r_py    <= i_y;
            r_max_x <= {1'b1, {(W-1){1'b0}}};
            r_max_y <= {1'b1, {(W-1){1'b0}}};
        end else if (r_rd_valid && !r_rd_edge) begin
            if (r_rd_x > r_max_x) begin
                r_max_x <= r_rd_x;
            end
            if (r_rd_y > r_max_y) begin
                r_max_y <= r_rd_y;
            end
        end
    end

    // Stage 1: vectors of the segment P->T and of the edge A->B.
    assign w_s1x = r_max_x + S1W'(1) - r_px;
    assign w_s1y = r_max_y + S1W'(1) - r_py;
    assign w_s2x = r_rd_x - r_ax;
    assign w_s2y = r_rd_y - r_ay;
    assign w_dx  = r_px - r_ax;
    assign w_dy  = r_py - r_ay;

    always_ff @(posedge i_clk) begin
        if (r_rd_valid && r_rd_edge) begin
            r_ax <= r_rd_x;
            r_ay <= r_rd_y;
            r_s1x <= w_s1x;
            r_s1y <= w_s1y;
            r_s2x <= w_s2x;
            r_s2y <= w_s2y;
            r_dx  <= w_dx;
            r_dy  <= w_dy;
        end
    end

    // Stage 2: the six cross-product terms.
    always_ff @(posedge i_clk) begin
        r_p_den1 <= r_s1x * r_s2y;
        r_p_den2 <= r_s2x * r_s1y;
        r_p_sn1  <= r_s1x * r_dy;
        r_p_sn2  <= r_s1y * r_dx;
        r_p_tn1  <= r_s2x * r_dy;
        r_p_tn2  <= r_s2y * r_dx;
    end

    // Stage 3: denominator and both numerators.
    always_ff @(posedge i_clk) begin
        r_den <= SW'(r_p_den1) - SW'(r_p_den2);
        r_sn  <= SW'(r_p_sn1) - SW'(r_p_sn2);
        r_tn  <= SW'(r_p_tn1) - SW'(r_p_tn2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= r_rd_valid && r_rd_edge && !r_rd_first;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 4: both ratios must lie in [0,1]; a zero denominator never counts.
    always_comb begin
        if (!r_den[SW-1]) begin
            w_sn_ok = !r_sn[SW-1] && (r_sn <= r_den);
            w_tn_ok = !r_tn[SW-1] && (r_tn <= r_den);
        end else begin
            w_sn_ok = (r_sn <= 0) && (r_sn >= r_den);
            w_tn_ok = (r_tn <= 0) && (r_tn >= r_den);
        end
        w_crossed = (r_den != '0) && w_sn_ok && w_tn_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_count <= '0;
        end else if (r_v3 && w_crossed) begin
            r_count <= r_count + CROSS_W'(1);
        end
    end

    // Output register keeps the input side free while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_count;
        end
    end

    assign o_sts.busy       = r_rd_valid || r_v1 || r_v2 || r_v3;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_out_valid      = r_out_valid;
    assign o_inside_res     = r_out_count[0];
    assign o_crossing_count = r_out_count;

endmodule

`default_nettype wire

// ===== rtl/core/pipr_ctrl.sv =====
// Sequencer for loads and the two table sweeps of a query, and the vertex count register.
`default_nettype none

module pipr_ctrl
    import pipr_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire                            i_operation,
    input  wire [IDX_W-1:0]                i_index,
    input  wire                            i_cfg_valid,
    input  wire [COUNT_W-1:0]              i_cfg_data,
    input  wire t_dp_sts                   i_sts,
    output t_dp_cmd                        o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] o_rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic [COUNT_W-1:0] r_vertex_count;
    logic [NW-1:0]      w_n;
    logic               w_last, w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // A count above the table depth acts as the depth.
    assign w_n      = (32'(r_vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                          : NW'(r_vertex_count);
    assign w_last   = (NW'(r_addr) == w_n - NW'(1));
    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_IDLE: begin
                n_addr = '0;
                if (w_accept && i_operation == OP_QUERY) begin
                    n_state = (w_n == '0) ? ST_DRAIN : ST_MAX;
                end
            end
            ST_MAX: begin
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_EDGE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_EDGE: begin
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy && i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_rd_addr  = r_addr;
        case (r_state)
            ST_IDLE: begin
                o_s_tready        = 1'b1;
                o_cmd.clear       = w_accept && i_operation == OP_QUERY;
                o_cmd.load_vertex = w_accept && i_operation == OP_LOAD
                                    && (32'(i_index) < MAX_VERTICES);
            end
            ST_MAX: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_EDGE: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_edge  = 1'b1;
                o_cmd.rd_first = (r_addr == '0);
            end
            ST_DRAIN: begin
                o_cmd.out_load = !i_sts.busy && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_query_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_QUERY) |=> (r_state == ST_MAX || r_state == ST_DRAIN))
        else $error("query request did not start a sweep");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_sts.busy && i_sts.out_free))
        else $error("result written while edge tests in flight or output occupied");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAX || r_state == ST_EDGE) |-> (NW'(r_addr) < w_n))
        else $error("sweep address beyond vertex count");

    a_edge_follows_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAX && w_last) |=> (r_state == ST_EDGE && r_addr == '0))
        else $error("edge pass did not start at entry zero");

endmodule

`default_nettype wire
